FILE: rtl/core/cascaded_grid_trilinear_lookup_assert.svh
// Assertion macros shared by the lookup block.
`ifndef CASCADED_GRID_TRILINEAR_LOOKUP_ASSERT_SVH
`define CASCADED_GRID_TRILINEAR_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CGTL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CGTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cgtl_pkg.sv
`default_nettype none
package cgtl_pkg;
	localparam int POS_W       = 32;
	localparam int REL_W       = 33;
	localparam int MAG_W       = 32;
	localparam int SP_W        = 31;
	localparam int CASC_W      = 2;
	localparam int NUM_SP      = 4;
	localparam int IDX_W       = 11;
	localparam int WEIGHT_W    = 17;
	localparam int CORNER_W    = 3;
	localparam int NUM_CORNERS = 8;
	localparam int DIST_W      = 68;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [2:0] REG_SPACING_0 = 3'd3;
	localparam logic [2:0] REG_SPACING_1 = 3'd4;
	localparam logic [2:0] REG_SPACING_2 = 3'd5;
	localparam logic [2:0] REG_SPACING_3 = 3'd6;

	localparam logic [SP_W-1:0] SPACING_RESET = 31'd65536;

	typedef struct packed {
		logic [2:0][REL_W-1:0] rel;
		logic [CASC_W-1:0]     cascade;
		logic [SP_W-1:0]       sp;
	} sel_t;

	typedef struct packed {
		logic [NUM_CORNERS-1:0][IDX_W-1:0]    idx;
		logic [NUM_CORNERS-1:0][WEIGHT_W-1:0] wt;
	} corners_t;
endpackage
`default_nettype wire

FILE: rtl/core/cgtl_cascade.sv
`default_nettype none
module cgtl_cascade #(
	parameter int PROBE_DIM = 8,
	parameter int CASCADES = 4
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        en,
	input  wire logic                                        in_valid,
	input  wire logic [2:0][cgtl_pkg::POS_W-1:0]             pos,
	input  wire logic [2:0][cgtl_pkg::POS_W-1:0]             origin,
	input  wire logic [cgtl_pkg::NUM_SP-1:0][cgtl_pkg::SP_W-1:0] spacing,
	output logic                                             out_valid,
	output cgtl_pkg::sel_t                                   out_sel
);
	localparam int TW   = cgtl_pkg::SP_W + $clog2(PROBE_DIM);
	localparam int H    = (TW + 1) / 2;
	localparam int HW   = TW - H;
	localparam int CMPW = (2 * TW > cgtl_pkg::DIST_W) ? 2 * TW : cgtl_pkg::DIST_W;
	localparam int NTH  = (CASCADES > 1) ? CASCADES - 1 : 1;

	logic v_s1, v_s2, v_s3;
	logic [2:0][cgtl_pkg::REL_W-1:0] rel_s1, rel_s2, rel_s3;
	logic [2:0][2*cgtl_pkg::MAG_W-1:0] sq_s2;
	logic [NTH-1:0][2*HW-1:0] hh_s2;
	logic [NTH-1:0][TW-1:0]   hl_s2;
	logic [NTH-1:0][2*H-1:0]  ll_s2;
	logic [cgtl_pkg::DIST_W-1:0] dist_s3;
	logic [NTH-1:0][CMPW-1:0] thr_s3;

	logic [2:0][cgtl_pkg::MAG_W-1:0] mag;
	logic [NTH-1:0][TW-1:0] thr_base;
	logic [cgtl_pkg::CASC_W-1:0] cas;
	logic [cgtl_pkg::DIST_W-3:0] dsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	// stage 1: position relative to the origin, full width
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				rel_s1[a] <= {pos[a][cgtl_pkg::POS_W-1], pos[a]}
					- {origin[a][cgtl_pkg::POS_W-1], origin[a]};
			end
		end
	end

	// stage 2: squared magnitudes; threshold split into half-width products
	always_comb begin
		logic [cgtl_pkg::REL_W-1:0] neg;
		for (int a = 0; a < 3; a++) begin
			neg = '0 - rel_s1[a];
			mag[a] = rel_s1[a][cgtl_pkg::REL_W-1] ? neg[cgtl_pkg::MAG_W-1:0]
				: rel_s1[a][cgtl_pkg::MAG_W-1:0];
		end
		for (int i = 0; i < NTH; i++) begin
			thr_base[i] = TW'(spacing[i]) * TW'(PROBE_DIM);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s2 <= rel_s1;
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= mag[a] * mag[a];
			end
			for (int i = 0; i < NTH; i++) begin
				hh_s2[i] <= thr_base[i][TW-1:H] * thr_base[i][TW-1:H];
				hl_s2[i] <= TW'(thr_base[i][TW-1:H]) * TW'(thr_base[i][H-1:0]);
				ll_s2[i] <= thr_base[i][H-1:0] * thr_base[i][H-1:0];
			end
		end
	end

	// stage 3: 4*|rel|^2 and (spacing*DIM)^2
	assign dsum = (cgtl_pkg::DIST_W-2)'(sq_s2[0]) + (cgtl_pkg::DIST_W-2)'(sq_s2[1])
		+ (cgtl_pkg::DIST_W-2)'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s3 <= rel_s2;
			dist_s3 <= {dsum, 2'b00};
			for (int i = 0; i < NTH; i++) begin
				thr_s3[i] <= (CMPW'(hh_s2[i]) << (2 * H)) + (CMPW'(hl_s2[i]) << (H + 1))
					+ CMPW'(ll_s2[i]);
			end
		end
	end

	// stage 4: last cascade whose threshold the distance passes
	always_comb begin
		cas = '0;
		for (int i = 1; i < CASCADES; i++) begin
			if (CMPW'(dist_s3) > thr_s3[i-1]) begin
				cas = cgtl_pkg::CASC_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sel.rel <= rel_s3;
			out_sel.cascade <= cas;
			out_sel.sp <= spacing[cas];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/cgtl_div.sv
`default_nettype none
module cgtl_div #(
	parameter int PROBE_DIM = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    en,
	input  wire logic                                    in_valid,
	input  wire cgtl_pkg::sel_t                          in_sel,
	output logic                                         out_valid,
	output logic [2:0][$clog2(PROBE_DIM)+FRAC_BITS-1:0]  grid,
	output logic [cgtl_pkg::CASC_W-1:0]                  out_cascade
);
	localparam int CWB = $clog2(PROBE_DIM);
	localparam int QB  = CWB + FRAC_BITS;
	localparam int HIW = cgtl_pkg::MAG_W - CWB;
	localparam logic [QB-1:0] TOP = QB'((PROBE_DIM - 1) * (2 ** FRAC_BITS));

	logic                              v_s   [QB+1];
	logic [cgtl_pkg::CASC_W-1:0]       cas_s [QB+1];
	logic [cgtl_pkg::SP_W-1:0]         sp_s  [QB+1];
	logic [2:0]                        pos_s [QB+1];
	logic [2:0]                        sat_s [QB+1];
	logic [2:0][cgtl_pkg::SP_W-1:0]    rem_s [QB+1];
	logic [2:0][QB-1:0]                lq_s  [QB+1];

	logic [2:0]                     pos0, sat0;
	logic [2:0][cgtl_pkg::SP_W-1:0] rem0;
	logic [2:0][QB-1:0]             lq0;

	// numerator is rel << FRAC_BITS; its top part must stay below sp or the
	// quotient overflows the grid
	always_comb begin
		logic [cgtl_pkg::REL_W-1:0] r;
		logic [HIW-1:0] hi;
		for (int a = 0; a < 3; a++) begin
			r = in_sel.rel[a];
			hi = r[cgtl_pkg::MAG_W-1:CWB];
			pos0[a] = !r[cgtl_pkg::REL_W-1] && (r != '0);
			sat0[a] = 32'(hi) >= 32'(in_sel.sp);
			rem0[a] = cgtl_pkg::SP_W'(hi);
			lq0[a] = {r[CWB-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cas_s[0] <= in_sel.cascade;
			sp_s[0] <= in_sel.sp;
			pos_s[0] <= pos0;
			sat_s[0] <= sat0;
			rem_s[0] <= rem0;
			lq_s[0] <= lq0;
		end
	end

	// one quotient bit per stage; lq shifts numerator bits out, quotient in
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [2:0][cgtl_pkg::SP_W-1:0] rem_n;
		logic [2:0][QB-1:0]             lq_n;

		always_comb begin
			logic [cgtl_pkg::SP_W:0] r2;
			logic ge;
			for (int a = 0; a < 3; a++) begin
				r2 = {rem_s[k-1][a], lq_s[k-1][a][QB-1]};
				ge = r2 >= {1'b0, sp_s[k-1]};
				rem_n[a] = ge ? cgtl_pkg::SP_W'(r2 - {1'b0, sp_s[k-1]})
					: r2[cgtl_pkg::SP_W-1:0];
				lq_n[a] = {lq_s[k-1][a][QB-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cas_s[k] <= cas_s[k-1];
				sp_s[k] <= sp_s[k-1];
				pos_s[k] <= pos_s[k-1];
				sat_s[k] <= sat_s[k-1];
				rem_s[k] <= rem_n;
				lq_s[k] <= lq_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cascade <= cas_s[QB];
			for (int a = 0; a < 3; a++) begin
				if (!pos_s[QB][a]) begin
					grid[a] <= '0;
				end else if (sat_s[QB][a] || lq_s[QB][a] > TOP) begin
					grid[a] <= TOP;
				end else begin
					grid[a] <= lq_s[QB][a];
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/cgtl_corner.sv
`default_nettype none
module cgtl_corner #(
	parameter int PROBE_DIM = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic [2:0][$clog2(PROBE_DIM)+FRAC_BITS-1:0] grid,
	input  wire logic [cgtl_pkg::CASC_W-1:0]            cascade,
	output logic                                        out_valid,
	output cgtl_pkg::corners_t                          out_corners
);
	localparam int CWB   = $clog2(PROBE_DIM);
	localparam int QB    = CWB + FRAC_BITS;
	localparam int SHIFT = 3 * FRAC_BITS - 16;
	localparam int D2    = PROBE_DIM * PROBE_DIM;
	localparam int D3    = D2 * PROBE_DIM;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CWB-1:0] CMAX = CWB'(PROBE_DIM - 1);

	logic v_s1, v_s2;
	logic [2:0][1:0][CWB-1:0] c_s1, c_s2;
	logic [2:0][1:0][FRAC_BITS:0] w_s1;
	logic [cgtl_pkg::CASC_W-1:0] cas_s1, cas_s2;
	logic [3:0][2*FRAC_BITS+1:0] xy_s2;
	logic [1:0][FRAC_BITS:0] wz_s2;

	cgtl_pkg::corners_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	// stage 1: cell corners and per-axis factors
	always_ff @(posedge clk) begin
		if (en) begin
			cas_s1 <= cascade;
			for (int a = 0; a < 3; a++) begin
				c_s1[a][0] <= grid[a][QB-1:FRAC_BITS];
				c_s1[a][1] <= (grid[a][QB-1:FRAC_BITS] == CMAX) ? CMAX
					: grid[a][QB-1:FRAC_BITS] + CWB'(1);
				w_s1[a][0] <= ONE - {1'b0, grid[a][FRAC_BITS-1:0]};
				w_s1[a][1] <= {1'b0, grid[a][FRAC_BITS-1:0]};
			end
		end
	end

	// stage 2: x*y products for the four xy corners
	always_ff @(posedge clk) begin
		if (en) begin
			cas_s2 <= cas_s1;
			c_s2 <= c_s1;
			wz_s2 <= w_s1[2];
			for (int k = 0; k < 4; k++) begin
				xy_s2[k] <= w_s1[0][k % 2] * w_s1[1][k / 2];
			end
		end
	end

	// stage 3: full weight, truncated once, and probe index
	always_comb begin
		logic [3*FRAC_BITS+2:0] prod;
		logic [31:0] idx32;
		for (int k = 0; k < cgtl_pkg::NUM_CORNERS; k++) begin
			prod = (3*FRAC_BITS+3)'(xy_s2[k % 4]) * (3*FRAC_BITS+3)'(wz_s2[k / 4]);
			nxt.wt[k] = prod[SHIFT +: cgtl_pkg::WEIGHT_W];
			idx32 = 32'(cas_s2) * 32'(D3) + 32'(c_s2[2][k / 4]) * 32'(D2)
				+ 32'(c_s2[1][(k / 2) % 2]) * 32'(PROBE_DIM) + 32'(c_s2[0][k % 2]);
			nxt.idx[k] = idx32[cgtl_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_corners <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/cascaded_grid_trilinear_lookup.sv
// Each query's eight corners leave in order on the single result port, one corner
// per cycle while result_stall is low; that port limits how often queries are taken.
// The divider is a pipeline of one quotient bit per stage, so queries overlap in it;
// query_stall is raised only when a finished item waits for the output register.
// Reset (arst_n low, asynchronous) empties the pipeline and the output register,
// and sets origins to 0 and spacings to 65536.
`default_nettype none
`include "cascaded_grid_trilinear_lookup_assert.svh"
module cascaded_grid_trilinear_lookup #(
	parameter int PROBE_DIM = 8,
	parameter int CASCADES  = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [cgtl_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [cgtl_pkg::DATA_W-1:0]       pwdata,
	output logic [cgtl_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready,
	input  wire logic                              query_valid,
	output logic                                   query_stall,
	input  wire logic signed [cgtl_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [cgtl_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [cgtl_pkg::POS_W-1:0] pos_z,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic [cgtl_pkg::CORNER_W-1:0]          corner,
	output logic [cgtl_pkg::IDX_W-1:0]             probe_index,
	output logic [cgtl_pkg::WEIGHT_W-1:0]          weight,
	output logic                                   last
);
	localparam int QB = $clog2(PROBE_DIM) + FRAC_BITS;

	logic [2:0][cgtl_pkg::POS_W-1:0] origin_q;
	logic [cgtl_pkg::NUM_SP-1:0][cgtl_pkg::SP_W-1:0] spacing_q;
	logic [2:0] reg_idx;
	logic wr_en;

	logic adv, load;
	logic sel_valid, div_valid, corner_valid;
	cgtl_pkg::sel_t sel;
	logic [2:0][QB-1:0] grid;
	logic [cgtl_pkg::CASC_W-1:0] div_cascade;
	cgtl_pkg::corners_t corners;

	cgtl_pkg::corners_t ser_q;
	logic busy_q;
	logic [cgtl_pkg::CORNER_W-1:0] cnt_q;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			for (int i = 0; i < cgtl_pkg::NUM_SP; i++) begin
				spacing_q[i] <= cgtl_pkg::SPACING_RESET;
			end
		end else if (wr_en) begin
			case (reg_idx)
				cgtl_pkg::REG_ORIGIN_X: origin_q[0] <= pwdata;
				cgtl_pkg::REG_ORIGIN_Y: origin_q[1] <= pwdata;
				cgtl_pkg::REG_ORIGIN_Z: origin_q[2] <= pwdata;
				cgtl_pkg::REG_SPACING_0: spacing_q[0] <= pwdata[cgtl_pkg::SP_W-1:0];
				cgtl_pkg::REG_SPACING_1: spacing_q[1] <= pwdata[cgtl_pkg::SP_W-1:0];
				cgtl_pkg::REG_SPACING_2: spacing_q[2] <= pwdata[cgtl_pkg::SP_W-1:0];
				cgtl_pkg::REG_SPACING_3: spacing_q[3] <= pwdata[cgtl_pkg::SP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cgtl_pkg::REG_ORIGIN_X: prdata = origin_q[0];
			cgtl_pkg::REG_ORIGIN_Y: prdata = origin_q[1];
			cgtl_pkg::REG_ORIGIN_Z: prdata = origin_q[2];
			cgtl_pkg::REG_SPACING_0: prdata = {1'b0, spacing_q[0]};
			cgtl_pkg::REG_SPACING_1: prdata = {1'b0, spacing_q[1]};
			cgtl_pkg::REG_SPACING_2: prdata = {1'b0, spacing_q[2]};
			cgtl_pkg::REG_SPACING_3: prdata = {1'b0, spacing_q[3]};
			default: prdata = '0;
		endcase
	end

	// whole pipeline moves together; it only holds when its last stage has an
	// item that the output register cannot take yet
	assign load = !busy_q || (cnt_q == cgtl_pkg::LAST_CORNER && !result_stall);
	assign adv = !corner_valid || load;
	assign query_stall = !adv;

	cgtl_cascade #(
		.PROBE_DIM(PROBE_DIM),
		.CASCADES(CASCADES)
	) u_cascade (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(query_valid),
		.pos({pos_z, pos_y, pos_x}),
		.origin(origin_q),
		.spacing(spacing_q),
		.out_valid(sel_valid),
		.out_sel(sel)
	);

	cgtl_div #(
		.PROBE_DIM(PROBE_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(sel_valid),
		.in_sel(sel),
		.out_valid(div_valid),
		.grid(grid),
		.out_cascade(div_cascade)
	);

	cgtl_corner #(
		.PROBE_DIM(PROBE_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_corner (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(div_valid),
		.grid(grid),
		.cascade(div_cascade),
		.out_valid(corner_valid),
		.out_corners(corners)
	);

	// output register: one item's eight corners, sent in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= corner_valid;
			cnt_q <= '0;
		end else if (busy_q && !result_stall) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ser_q <= corners;
		end
	end

	assign result_valid = busy_q;
	assign corner = cnt_q;
	assign probe_index = ser_q.idx[cnt_q];
	assign weight = ser_q.wt[cnt_q];
	assign last = (cnt_q == cgtl_pkg::LAST_CORNER);

	`CGTL_ASSERT_NEXT(a_corner_step,
		result_valid && !result_stall && corner != cgtl_pkg::LAST_CORNER,
		result_valid && corner == $past(corner) + 3'd1, "corner sequence broken")
	`CGTL_ASSERT_NEXT(a_drain_idle,
		result_valid && !result_stall && last && !corner_valid,
		!result_valid, "output still valid after last corner with nothing queued")
	`CGTL_ASSERT_NEXT(a_hold_item, corner_valid && !adv, corner_valid,
		"pipeline item lost while held")
	`CGTL_ASSERT_SAME(a_weight_range, result_valid, weight <= 17'h10000,
		"weight above one")
endmodule
`default_nettype wire
